// ===== rtl/core/fhc_pkg.sv =====
// ----------------------------------------------------------------------------
// fhc_pkg
// Shared widths, term tables and types of the fuzzy heading controller.
// ----------------------------------------------------------------------------
package fhc_pkg;

    localparam int FRAC_BITS = 12;

    // field and datapath widths
    localparam int X_W       = 15;
    localparam int LIN_W     = 12;
    localparam int ANG_W     = 14;
    localparam int OFF_W     = 11;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;
    localparam int M_PAD_W   = M_TDATA_W - LIN_W - ANG_W;
    localparam int NSEG      = 11;
    localparam int SEG_W     = 4;
    localparam int NUM_W     = 12;
    localparam int K_W       = 10;
    localparam int P_W       = NUM_W + K_W;
    localparam int N_W       = P_W + 1;
    localparam int RCP_W     = 27;
    localparam int DIV_SHIFT = 36;
    localparam int Q_W       = N_W + RCP_W - DIV_SHIFT;
    localparam int VAL_W     = 16;

    localparam logic [OFF_W-1:0] OFF_RESET = 11'd1024;

    typedef enum logic [1:0] {
        LIN_S,
        LIN_M,
        LIN_L,
        LIN_VL
    } lin_term_t;

    typedef struct packed {
        logic             hit;
        logic             left;
        logic [SEG_W-1:0] seg;
    } fhc_tag_t;

    // thousandths to fixed point, round half away from zero
    function automatic int fx(input int milli);
        int mag;
        int v;
        mag = (milli < 0) ? -milli : milli;
        v   = ((mag << FRAC_BITS) + 500) / 1000;
        return (milli < 0) ? -v : v;
    endfunction

    // input terms, corners a < b < c
    localparam int IN_A [NSEG] = '{fx(-3150), fx(-2800), fx(-1100), fx(-600), fx(-400),
        fx(-100), fx(100), fx(400), fx(600), fx(1100), fx(2800)};
    localparam int IN_B [NSEG] = '{fx(-3000), fx(-1900), fx(-900), fx(-500), fx(-250),
        fx(0), fx(250), fx(500), fx(900), fx(1900), fx(3000)};
    localparam int IN_C [NSEG] = '{fx(-2800), fx(-1100), fx(-600), fx(-400), fx(-100),
        fx(100), fx(400), fx(600), fx(1100), fx(2800), fx(3150)};

    // angular rate terms, peak and right corner
    localparam int ANG_B [NSEG] = '{fx(-800), fx(-450), fx(-250), fx(-150), fx(-50),
        fx(0), fx(50), fx(150), fx(250), fx(450), fx(800)};
    localparam int ANG_C [NSEG] = '{fx(-600), fx(-310), fx(-190), fx(-100), fx(-25),
        fx(25), fx(100), fx(190), fx(310), fx(600), fx(1000)};

    // linear speed terms, peak and right corner before the offset
    localparam int LIN_B [4] = '{fx(35), fx(95), fx(150), fx(220)};
    localparam int LIN_C [4] = '{fx(70), fx(150), fx(200), fx(260)};

    localparam lin_term_t RULE_LIN [NSEG] = '{LIN_S, LIN_S, LIN_S, LIN_M, LIN_L, LIN_VL,
        LIN_L, LIN_M, LIN_S, LIN_S, LIN_S};

    localparam int LIN_MAX = fx(700);
    localparam int ANG_MAX = fx(1000);

endpackage

// ===== rtl/core/fhc_fuzzify.sv =====
// ----------------------------------------------------------------------------
// fhc_fuzzify
// Finds the one input term that fires and its membership numerator.
// ----------------------------------------------------------------------------
module fhc_fuzzify (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [fhc_pkg::X_W-1:0]    in_x,
    output logic                              out_valid,
    input  logic                              out_ready,
    output fhc_pkg::fhc_tag_t                 out_tag,
    output logic [fhc_pkg::NUM_W-1:0]         out_num
);

    logic                         valid_reg;
    fhc_pkg::fhc_tag_t            tag_reg;
    fhc_pkg::fhc_tag_t            tag_next;
    logic [fhc_pkg::NUM_W-1:0]    num_reg;
    logic [fhc_pkg::NUM_W-1:0]    num_next;
    logic signed [31:0]           x_ext;
    logic signed [31:0]           diff;
    logic [fhc_pkg::NSEG-1:0]     fire;
    int                           a_sel;
    int                           b_sel;
    int                           c_sel;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_num   = num_reg;

    // the terms tile the axis edge to edge, so at most one fires
    always_comb begin
        x_ext        = {{(32 - fhc_pkg::X_W){in_x[fhc_pkg::X_W-1]}}, in_x};
        tag_next.hit = 1'b0;
        tag_next.seg = '0;
        for (int g = 0; g < fhc_pkg::NSEG; g++) begin
            fire[g] = (x_ext > fhc_pkg::IN_A[g]) && (x_ext < fhc_pkg::IN_C[g]);
        end
        for (int g = 0; g < fhc_pkg::NSEG; g++) begin
            if (fire[g]) begin
                tag_next.hit = 1'b1;
                tag_next.seg = fhc_pkg::SEG_W'(g);
            end
        end
        a_sel         = fhc_pkg::IN_A[tag_next.seg];
        b_sel         = fhc_pkg::IN_B[tag_next.seg];
        c_sel         = fhc_pkg::IN_C[tag_next.seg];
        // at the peak the rising side gives num equal to den
        tag_next.left = (x_ext <= b_sel);
        diff          = tag_next.left ? (x_ext - a_sel) : (c_sel - x_ext);
        num_next      = diff[fhc_pkg::NUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            tag_reg <= tag_next;
            num_reg <= num_next;
        end
    end

endmodule

// ===== rtl/core/fhc_weight.sv =====
// ----------------------------------------------------------------------------
// fhc_weight
// Scales the membership numerator by the widths (c - b) of both output terms.
// ----------------------------------------------------------------------------
module fhc_weight (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fhc_pkg::fhc_tag_t             in_tag,
    input  logic [fhc_pkg::NUM_W-1:0]     in_num,
    output logic                          out_valid,
    input  logic                          out_ready,
    output fhc_pkg::fhc_tag_t             out_tag,
    output logic [fhc_pkg::P_W-1:0]       out_p_lin,
    output logic [fhc_pkg::P_W-1:0]       out_p_ang
);

    logic                        valid_reg;
    fhc_pkg::fhc_tag_t           tag_reg;
    logic [fhc_pkg::P_W-1:0]     p_lin_reg;
    logic [fhc_pkg::P_W-1:0]     p_lin_next;
    logic [fhc_pkg::P_W-1:0]     p_ang_reg;
    logic [fhc_pkg::P_W-1:0]     p_ang_next;
    logic [fhc_pkg::K_W-1:0]     k_lin;
    logic [fhc_pkg::K_W-1:0]     k_ang;
    fhc_pkg::lin_term_t          lin_term;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_tag   = tag_reg;
    assign out_p_lin = p_lin_reg;
    assign out_p_ang = p_ang_reg;

    // term width c - b; the speed offset moves both corners so it drops out
    always_comb begin
        lin_term   = fhc_pkg::RULE_LIN[in_tag.seg];
        k_lin      = fhc_pkg::K_W'(fhc_pkg::LIN_C[lin_term] - fhc_pkg::LIN_B[lin_term]);
        k_ang      = fhc_pkg::K_W'(fhc_pkg::ANG_C[in_tag.seg] - fhc_pkg::ANG_B[in_tag.seg]);
        p_lin_next = fhc_pkg::P_W'(k_lin) * fhc_pkg::P_W'(in_num);
        p_ang_next = fhc_pkg::P_W'(k_ang) * fhc_pkg::P_W'(in_num);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            tag_reg   <= in_tag;
            p_lin_reg <= p_lin_next;
            p_ang_reg <= p_ang_next;
        end
    end

endmodule

// ===== rtl/core/fhc_defuzz.sv =====
// ----------------------------------------------------------------------------
// fhc_defuzz
// Right edge of the clipped output terms, saturation and the result register.
// ----------------------------------------------------------------------------
module fhc_defuzz (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  fhc_pkg::fhc_tag_t             in_tag,
    input  logic [fhc_pkg::P_W-1:0]       in_p_lin,
    input  logic [fhc_pkg::P_W-1:0]       in_p_ang,
    input  logic [fhc_pkg::OFF_W-1:0]     speed_offset,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [fhc_pkg::LIN_W-1:0]     out_lin,
    output logic [fhc_pkg::ANG_W-1:0]     out_ang,
    output logic                          out_res
);

    localparam int PROD_W = fhc_pkg::N_W + fhc_pkg::RCP_W;

    logic                                 valid_reg;
    logic [fhc_pkg::LIN_W-1:0]            lin_reg;
    logic [fhc_pkg::LIN_W-1:0]            lin_next;
    logic [fhc_pkg::ANG_W-1:0]            ang_reg;
    logic [fhc_pkg::ANG_W-1:0]            ang_next;
    logic                                 res_reg;
    logic                                 res_next;

    logic [fhc_pkg::NUM_W-1:0]            den_l [fhc_pkg::NSEG];
    logic [fhc_pkg::NUM_W-1:0]            den_r [fhc_pkg::NSEG];
    logic [fhc_pkg::RCP_W-1:0]            rcp_l [fhc_pkg::NSEG];
    logic [fhc_pkg::RCP_W-1:0]            rcp_r [fhc_pkg::NSEG];

    logic [fhc_pkg::NUM_W-1:0]            den_sel;
    logic [fhc_pkg::RCP_W-1:0]            rcp_sel;
    logic [fhc_pkg::N_W-1:0]              n_lin;
    logic [fhc_pkg::N_W-1:0]              n_ang;
    logic [PROD_W-1:0]                    prod_lin;
    logic [PROD_W-1:0]                    prod_ang;
    logic [fhc_pkg::Q_W-1:0]              q_lin;
    logic [fhc_pkg::Q_W-1:0]              q_ang;
    logic [fhc_pkg::VAL_W-1:0]            off_add;
    logic signed [fhc_pkg::VAL_W-1:0]     lin_val;
    logic signed [fhc_pkg::VAL_W-1:0]     ang_val;
    fhc_pkg::lin_term_t                   lin_term;

    // floor(n / d) = (n * ceil(2^36 / d)) >> 36, exact for n below 2^23, d up to 2^13
    for (genvar g = 0; g < fhc_pkg::NSEG; g++) begin : g_rcp
        localparam int DL = fhc_pkg::IN_B[g] - fhc_pkg::IN_A[g];
        localparam int DR = fhc_pkg::IN_C[g] - fhc_pkg::IN_B[g];
        localparam longint unsigned RL =
            ((64'd1 << fhc_pkg::DIV_SHIFT) + 64'(2 * DL) - 64'd1) / 64'(2 * DL);
        localparam longint unsigned RR =
            ((64'd1 << fhc_pkg::DIV_SHIFT) + 64'(2 * DR) - 64'd1) / 64'(2 * DR);
        assign den_l[g] = fhc_pkg::NUM_W'(DL);
        assign den_r[g] = fhc_pkg::NUM_W'(DR);
        assign rcp_l[g] = fhc_pkg::RCP_W'(RL);
        assign rcp_r[g] = fhc_pkg::RCP_W'(RR);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_lin   = lin_reg;
    assign out_ang   = ang_reg;
    assign out_res   = res_reg;

    always_comb begin
        den_sel  = in_tag.left ? den_l[in_tag.seg] : den_r[in_tag.seg];
        rcp_sel  = in_tag.left ? rcp_l[in_tag.seg] : rcp_r[in_tag.seg];
        // round(k * num / den) = floor((2 * k * num + den) / (2 * den))
        n_lin    = {in_p_lin, 1'b0} + fhc_pkg::N_W'(den_sel);
        n_ang    = {in_p_ang, 1'b0} + fhc_pkg::N_W'(den_sel);
        prod_lin = PROD_W'(n_lin) * PROD_W'(rcp_sel);
        prod_ang = PROD_W'(n_ang) * PROD_W'(rcp_sel);
        q_lin    = prod_lin[fhc_pkg::DIV_SHIFT +: fhc_pkg::Q_W];
        q_ang    = prod_ang[fhc_pkg::DIV_SHIFT +: fhc_pkg::Q_W];

        lin_term = fhc_pkg::RULE_LIN[in_tag.seg];
        off_add  = (lin_term == fhc_pkg::LIN_L || lin_term == fhc_pkg::LIN_VL) ?
                   fhc_pkg::VAL_W'(speed_offset) : '0;
        lin_val  = fhc_pkg::VAL_W'(fhc_pkg::LIN_C[lin_term]) + off_add
                   - fhc_pkg::VAL_W'(q_lin);
        ang_val  = fhc_pkg::VAL_W'(fhc_pkg::ANG_C[in_tag.seg]) - fhc_pkg::VAL_W'(q_ang);

        if (lin_val < 0) begin
            lin_val = '0;
        end else if (lin_val > fhc_pkg::LIN_MAX) begin
            lin_val = fhc_pkg::VAL_W'(fhc_pkg::LIN_MAX);
        end
        if (ang_val > fhc_pkg::ANG_MAX) begin
            ang_val = fhc_pkg::VAL_W'(fhc_pkg::ANG_MAX);
        end else if (ang_val < -fhc_pkg::ANG_MAX) begin
            ang_val = fhc_pkg::VAL_W'(-fhc_pkg::ANG_MAX);
        end

        // nothing fired: all-zero result
        if (in_tag.hit) begin
            lin_next = lin_val[fhc_pkg::LIN_W-1:0];
            ang_next = ang_val[fhc_pkg::ANG_W-1:0];
            res_next = 1'b1;
        end else begin
            lin_next = '0;
            ang_next = '0;
            res_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            lin_reg <= lin_next;
            ang_reg <= ang_next;
            res_reg <= res_next;
        end
    end

endmodule

// ===== rtl/core/fuzzy_heading_controller_top.sv =====
// ----------------------------------------------------------------------------
// fuzzy_heading_controller_top
// Single-input fuzzy controller: heading error in, speed and turn rate out.
// ----------------------------------------------------------------------------
// Input stream s_*: one beat carries a heading error (signed, 4096 = 1.0 rad).
// Output stream m_*: one beat per input beat, in order, with the linear speed
// and angular rate commands; m_tuser is high when an input term fired and low
// (with zero data) when the angle sits on a shared term corner or out of range.
// cfg_*: writes the speed offset applied to the fast speed terms; always ready,
// read by the last stage, so write it only while no beat is in flight.
// Pipeline: input register, term search, width multiply, reciprocal divide with
// rounding and saturation into the output register. A result shows on m_tvalid
// after its beat has moved through each of these registers in turn.
// Throughput is one beat per cycle while m_tready is high; each stage moves on
// when the stage after it is empty or moving, so a stalled output still lets
// upstream bubbles fill and s_tready only drops once all four stages hold data.
// Reset (aresetn low at a clock edge) empties the pipeline and restores the
// offset to 1024 (0.25).
// ----------------------------------------------------------------------------
module fuzzy_heading_controller_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [fhc_pkg::S_TDATA_W-1:0]        s_tdata,   // [14:0] heading_error
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fhc_pkg::M_TDATA_W-1:0]        m_tdata,   // [11:0] linear_speed,
                                                            // [25:12] angular_rate
    output logic                                 m_tuser,   // [0] valid_res
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fhc_pkg::OFF_W-1:0]            cfg_data
);

    logic [fhc_pkg::OFF_W-1:0]           offset_reg;
    logic                                in_valid_reg;
    logic signed [fhc_pkg::X_W-1:0]      x_reg;

    logic                                fz_ready;
    logic                                fz_valid;
    fhc_pkg::fhc_tag_t                   fz_tag;
    logic [fhc_pkg::NUM_W-1:0]           fz_num;

    logic                                wt_ready;
    logic                                wt_valid;
    fhc_pkg::fhc_tag_t                   wt_tag;
    logic [fhc_pkg::P_W-1:0]             wt_p_lin;
    logic [fhc_pkg::P_W-1:0]             wt_p_ang;

    logic                                df_ready;
    logic [fhc_pkg::LIN_W-1:0]           df_lin;
    logic [fhc_pkg::ANG_W-1:0]           df_ang;
    logic                                df_res;

    assign cfg_ready = 1'b1;
    assign s_tready  = !in_valid_reg || fz_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= fhc_pkg::OFF_RESET;
        end else if (cfg_valid) begin
            offset_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            x_reg <= s_tdata[fhc_pkg::X_W-1:0];
        end
    end

    fhc_fuzzify u_fuzzify (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (fz_ready),
        .in_x      (x_reg),
        .out_valid (fz_valid),
        .out_ready (wt_ready),
        .out_tag   (fz_tag),
        .out_num   (fz_num)
    );

    fhc_weight u_weight (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fz_valid),
        .in_ready  (wt_ready),
        .in_tag    (fz_tag),
        .in_num    (fz_num),
        .out_valid (wt_valid),
        .out_ready (df_ready),
        .out_tag   (wt_tag),
        .out_p_lin (wt_p_lin),
        .out_p_ang (wt_p_ang)
    );

    fhc_defuzz u_defuzz (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (wt_valid),
        .in_ready     (df_ready),
        .in_tag       (wt_tag),
        .in_p_lin     (wt_p_lin),
        .in_p_ang     (wt_p_ang),
        .speed_offset (offset_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_lin      (df_lin),
        .out_ang      (df_ang),
        .out_res      (df_res)
    );

    assign m_tdata = {{fhc_pkg::M_PAD_W{1'b0}}, df_ang, df_lin};
    assign m_tuser = df_res;

endmodule

// ===== rtl/core/fhc_checker.sv =====
// ----------------------------------------------------------------------------
// fhc_checker
// Port-level checks of the fuzzy heading controller, bound to the top level.
// ----------------------------------------------------------------------------
module fhc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [fhc_pkg::M_TDATA_W-1:0]     m_tdata,
    input logic                              m_tuser
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat present right after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // a beat where nothing fired carries zero commands
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("no-fire beat with nonzero data");

    // commands stay inside their saturation limits
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[11:0] <= 12'(fhc_pkg::LIN_MAX))
                  && ($signed(m_tdata[25:12]) <= 14'sd4096)
                  && ($signed(m_tdata[25:12]) >= -14'sd4096))
        else $error("command outside saturation range");

endmodule

bind fuzzy_heading_controller_top fhc_checker u_fhc_checker (.*);

// ===== sim/tb_fuzzy_heading_controller_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fuzzy_heading_controller_top
// Streams heading errors through the fuzzy controller and checks every speed
// and turn rate beat against an in-bench prediction of the rule base, over
// several fast speed offsets, with random gaps and back pressure.
// ----------------------------------------------------------------------------
module tb_fuzzy_heading_controller_top;

    localparam int IDLE_PCT    = 17;
    localparam int LATENCY     = 3;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RAND_ITEMS  = 274;
    localparam int NUM_PHASES  = 5;

    typedef logic signed [fhc_pkg::X_W-1:0] heading_t;

    typedef struct packed {
        logic [fhc_pkg::LIN_W-1:0]        speed;
        logic signed [fhc_pkg::ANG_W-1:0] turn;
        logic                             fired;
    } heading_cmd_t;

    // rule base in thousandths: input triangles, turn and speed output edges
    localparam int TERM_A [fhc_pkg::NSEG] = '{-3150, -2800, -1100, -600, -400, -100, 100,
        400, 600, 1100, 2800};
    localparam int TERM_B [fhc_pkg::NSEG] = '{-3000, -1900, -900, -500, -250, 0, 250, 500,
        900, 1900, 3000};
    localparam int TERM_C [fhc_pkg::NSEG] = '{-2800, -1100, -600, -400, -100, 100, 400, 600,
        1100, 2800, 3150};
    localparam int TURN_PEAK [fhc_pkg::NSEG] = '{-800, -450, -250, -150, -50, 0, 50, 150,
        250, 450, 800};
    localparam int TURN_EDGE [fhc_pkg::NSEG] = '{-600, -310, -190, -100, -25, 25, 100, 190,
        310, 600, 1000};
    localparam int SPEED_PEAK [4] = '{35, 95, 150, 220};
    localparam int SPEED_EDGE [4] = '{70, 150, 200, 260};
    localparam fhc_pkg::lin_term_t SPEED_RULE [fhc_pkg::NSEG] = '{fhc_pkg::LIN_S,
        fhc_pkg::LIN_S, fhc_pkg::LIN_S, fhc_pkg::LIN_M, fhc_pkg::LIN_L, fhc_pkg::LIN_VL,
        fhc_pkg::LIN_L, fhc_pkg::LIN_M, fhc_pkg::LIN_S, fhc_pkg::LIN_S, fhc_pkg::LIN_S};
    localparam int CORNER_MILLI [12] = '{-3150, -2800, -1100, -600, -400, -100, 100, 400,
        600, 1100, 2800, 3150};
    localparam logic [fhc_pkg::OFF_W-1:0] PHASE_OFFSET [NUM_PHASES] = '{11'd1024, 11'd0,
        11'd1638, 11'd2047, 11'd1024};

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [fhc_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [fhc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [fhc_pkg::OFF_W-1:0]     cfg_data  = '0;

    heading_t                  heading_q[$];
    heading_cmd_t              command_q[$];
    heading_cmd_t              want_cmd;
    logic [fhc_pkg::OFF_W-1:0] speed_offset = 11'd1024;
    bit                        steady = 1'b0;
    int                        err_count = 0;
    int                        cycle_count = 0;

    fuzzy_heading_controller_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // [14:0] heading_error
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // [11:0] linear_speed, [25:12] angular_rate
        .m_tuser   (m_tuser),    // [0] valid_res
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // thousandths to Q3.12, half away from zero
    function automatic longint milli_q(input int milli);
        longint mag;
        longint v;
        mag = (milli < 0) ? -longint'(milli) : longint'(milli);
        v   = ((mag <<< fhc_pkg::FRAC_BITS) + 500) / 1000;
        return (milli < 0) ? -v : v;
    endfunction

    // right edge of a triangle clipped at num/den, rounded half up
    function automatic longint clipped_edge(input longint b, input longint c,
                                            input longint num, input longint den);
        return c - (2 * (c - b) * num + den) / (2 * den);
    endfunction

    function automatic heading_cmd_t predict_command(input heading_t err,
                                                     input logic [fhc_pkg::OFF_W-1:0] off);
        longint             x, a, b, c, num, den, lb, lc, yl, ya;
        longint             best_num, best_den, speed, turn;
        bit                 found;
        fhc_pkg::lin_term_t k;
        heading_cmd_t       cmd;
        x        = longint'(err);
        found    = 1'b0;
        best_num = 0;
        best_den = 1;
        speed    = 0;
        turn     = 0;
        for (int i = 0; i < fhc_pkg::NSEG; i++) begin
            a = milli_q(TERM_A[i]);
            b = milli_q(TERM_B[i]);
            c = milli_q(TERM_C[i]);
            if (x <= a || x >= c) continue;
            if (x == b) begin
                num = 1;
                den = 1;
            end else if (x < b) begin
                num = x - a;
                den = b - a;
            end else begin
                num = c - x;
                den = c - b;
            end
            k  = SPEED_RULE[i];
            lb = milli_q(SPEED_PEAK[k]);
            lc = milli_q(SPEED_EDGE[k]);
            if (k == fhc_pkg::LIN_L || k == fhc_pkg::LIN_VL) begin
                lb += longint'(off);
                lc += longint'(off);
            end
            yl = clipped_edge(lb, lc, num, den);
            ya = clipped_edge(milli_q(TURN_PEAK[i]), milli_q(TURN_EDGE[i]), num, den);
            if (!found || num * best_den > best_num * den) begin
                found    = 1'b1;
                best_num = num;
                best_den = den;
                speed    = yl;
                turn     = ya;
            end else if (num * best_den == best_num * den) begin
                if (yl > speed) speed = yl;
                if (ya > turn) turn = ya;
            end
        end
        cmd = '0;
        if (found) begin
            if (speed < 0) speed = 0;
            if (speed > milli_q(700)) speed = milli_q(700);
            if (turn > milli_q(1000)) turn = milli_q(1000);
            if (turn < -milli_q(1000)) turn = -milli_q(1000);
            cmd.speed = speed[fhc_pkg::LIN_W-1:0];
            cmd.turn  = turn[fhc_pkg::ANG_W-1:0];
            cmd.fired = 1'b1;
        end
        return cmd;
    endfunction

    function automatic heading_t random_heading();
        int r;
        r = $urandom_range(99);
        if (r < 60) return heading_t'(int'($urandom_range(25736)) - 12868);
        // close to a shared corner or the outer limits
        if (r < 80)
            return heading_t'(milli_q(CORNER_MILLI[$urandom_range(11)])
                + longint'(int'($urandom_range(6)) - 3));
        return heading_t'($urandom());
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        err_count++;
    endtask

    // waits for the pipe to empty, then lets it settle
    task automatic wait_drained();
        while (heading_q.size() != 0 || s_tvalid || command_q.size() != 0)
            @(negedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_offset(input logic [fhc_pkg::OFF_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (heading_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, heading_q.pop_front()};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: offset writes, accepted headings and result beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) speed_offset = cfg_data;
            if (s_tvalid && s_tready)
                command_q.push_back(predict_command(heading_t'(s_tdata[fhc_pkg::X_W-1:0]),
                                                    speed_offset));
            if (m_tvalid && m_tready) begin
                if (command_q.size() == 0) begin
                    report_mismatch("unexpected result beat, linear_speed",
                                    m_tdata[fhc_pkg::LIN_W-1:0], 0);
                end else begin
                    want_cmd = command_q.pop_front();
                    if (m_tdata[fhc_pkg::LIN_W-1:0] !== want_cmd.speed)
                        report_mismatch("linear_speed", m_tdata[fhc_pkg::LIN_W-1:0],
                                        want_cmd.speed);
                    if (m_tdata[fhc_pkg::LIN_W +: fhc_pkg::ANG_W] !== want_cmd.turn)
                        report_mismatch("angular_rate",
                                        $signed(m_tdata[fhc_pkg::LIN_W +: fhc_pkg::ANG_W]),
                                        want_cmd.turn);
                    if (m_tuser !== want_cmd.fired)
                        report_mismatch("valid_res", m_tuser, want_cmd.fired);
                end
            end
        end
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_fuzzy_heading_controller_top: FAIL");
        $finish;
    end

    initial begin
        heading_t                  edge_cases[$];
        logic [fhc_pkg::OFF_W-1:0] off_value;
        edge_cases = '{heading_t'(-16384), heading_t'(16383), heading_t'(-12868),
            heading_t'(12868), heading_t'(0), heading_t'(-1), heading_t'(1),
            heading_t'(milli_q(-3150) + 1), heading_t'(milli_q(3150) - 1),
            heading_t'(milli_q(-3000)), heading_t'(milli_q(3000)),
            heading_t'(milli_q(250)), heading_t'(milli_q(-250)),
            heading_t'(milli_q(100) + 1)};
        // every shared corner and both outer limits: nothing fires there
        foreach (CORNER_MILLI[j]) edge_cases.push_back(heading_t'(milli_q(CORNER_MILLI[j])));

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p != 0) begin
                wait_drained();
                off_value = (p == NUM_PHASES - 1) ? fhc_pkg::OFF_W'($urandom_range(1638))
                                                  : PHASE_OFFSET[p];
                write_offset(off_value);
            end
            steady = (p == 3);
            foreach (edge_cases[j]) heading_q.push_back(edge_cases[j]);
            for (int n = 0; n < RAND_ITEMS; n++) begin
                if (p == 2 && n == RAND_ITEMS / 2) wait_drained();
                heading_q.push_back(random_heading());
            end
        end

        wait_drained();
        repeat (4 * LATENCY) @(posedge aclk);
        if (err_count == 0) begin
            $display("tb_fuzzy_heading_controller_top: PASS");
        end else begin
            $display("tb_fuzzy_heading_controller_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/fhc_pkg.sv
rtl/core/fhc_fuzzify.sv
rtl/core/fhc_weight.sv
rtl/core/fhc_defuzz.sv
rtl/core/fuzzy_heading_controller_top.sv
rtl/core/fhc_checker.sv
sim/tb_fuzzy_heading_controller_top.sv
